// ----- rtl/core/mnap_pkg.sv -----
// Package for the mangled-name parameter classifier.
// Holds the word structs, the parse phase enum and the character codes.
// No dependencies.
package mnap_pkg;

  localparam int MaxArgsDefault   = 64;
  localparam int SkipWidthDefault = 16;

  localparam logic [7:0] ChUnderscore = 8'h5F;
  localparam logic [7:0] ChZ          = 8'h5A;
  localparam logic [7:0] ChP          = 8'h50;
  localparam logic [7:0] ChF          = 8'h66;
  localparam logic [7:0] ChI          = 8'h69;
  localparam logic [7:0] ChL          = 8'h6C;
  localparam logic [7:0] ChS          = 8'h53;
  localparam logic [7:0] ChV          = 8'h76;
  localparam logic [7:0] ChZero       = 8'h30;
  localparam logic [7:0] ChNine       = 8'h39;

  typedef enum logic [3:0] {
    PH_PREFIX0  = 4'd0,
    PH_PREFIX1  = 4'd1,
    PH_NAME_LEN = 4'd2,
    PH_SKIP     = 4'd3,
    PH_PARAMS   = 4'd4,
    PH_AFTER_P  = 4'd5,
    PH_P_LEN    = 4'd6,
    PH_S_SKIP   = 4'd7,
    PH_HALT     = 4'd8
  } phase_t;

  typedef struct packed {
    logic [7:0] character;
    logic       last_char;
  } char_word_t;

  typedef struct packed {
    logic       arg_valid;
    logic       arg_is_handle;
    logic [5:0] arg_index;
    logic       done_res;
    logic [6:0] arg_count;
    logic       parse_error;
  } res_word_t;

endpackage

// ----- rtl/core/mangled_name_arg_kind_parser.sv -----
// Top level of the mangled-name parameter classifier.
// Depends on mnap_pkg for word types, phase enum and character codes.
//
// Usage: a mangled name enters on the char channel, one byte per word, with
// last_char set on its final byte. Every accepted byte yields exactly one
// word on the res channel. A res word flags a classified parameter (index,
// handle or plain value); on the final byte it also carries done_res, the
// parameter count and the sticky error flag. After the final byte the parser
// returns to its start state, so the next byte begins a new name.
// The res word for a byte is registered and valid in the cycle after acceptance.
// One byte is taken per cycle while char_stall is low; the parse state is a single register set
// updated by one level of decode logic per byte.
// Reset clears the parse state and res_valid; the result word itself is not reset.
// While res_stall holds a pending word, char_stall is high and no byte is
// taken; once the word is taken, a new byte can be accepted in the same cycle.
module mangled_name_arg_kind_parser #(
  parameter int MAX_ARGS   = mnap_pkg::MaxArgsDefault,
  parameter int SKIP_WIDTH = mnap_pkg::SkipWidthDefault
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 char_valid,
  output logic                 char_stall,
  input  mnap_pkg::char_word_t char_word,
  output logic                 res_valid,
  input  logic                 res_stall,
  output mnap_pkg::res_word_t  res_word
);

  localparam int CW = $clog2(MAX_ARGS + 1);

  mnap_pkg::phase_t phase, phase_next, phase_upd;
  logic [SKIP_WIDTH-1:0] skip_count, skip_next, skip_upd, skip_dec, skip_acc;
  logic [CW-1:0] param_count, param_count_next, cnt_upd;
  logic error_flag, error_flag_next, err_upd;

  logic [7:0] c;
  logic last, accept, is_digit, full, code_path, a_valid, a_handle;
  logic [SKIP_WIDTH+3:0] acc_wide;
  logic [3:0] digit;
  logic [CW+6:0] idx_ext, cnt_ext;
  mnap_pkg::res_word_t res_calc;

  assign c        = char_word.character;
  assign last     = char_word.last_char;
  assign accept   = char_valid & ~char_stall;
  assign char_stall = res_valid & res_stall;

  assign is_digit = (c >= mnap_pkg::ChZero) && (c <= mnap_pkg::ChNine);
  assign digit    = 4'(c - mnap_pkg::ChZero);
  assign acc_wide = ({4'd0, skip_count} << 3) + ({4'd0, skip_count} << 1)
                    + {{SKIP_WIDTH{1'b0}}, digit};
  assign skip_acc = (acc_wide[SKIP_WIDTH+3:SKIP_WIDTH] != 4'd0) ? '1
                    : acc_wide[SKIP_WIDTH-1:0];
  assign skip_dec = skip_count - 1'b1;
  assign full     = param_count >= CW'(MAX_ARGS);

  always_comb begin
    phase_upd = phase;
    skip_upd  = skip_count;
    cnt_upd   = param_count;
    err_upd   = error_flag;
    a_valid   = 1'b0;
    a_handle  = 1'b0;
    code_path = 1'b0;
    unique case (phase) inside
      mnap_pkg::PH_PREFIX0: begin
        if (c != mnap_pkg::ChUnderscore || last) begin
          err_upd   = 1'b1;
          phase_upd = mnap_pkg::PH_HALT;
        end else begin
          phase_upd = mnap_pkg::PH_PREFIX1;
        end
      end
      mnap_pkg::PH_PREFIX1: begin
        if (c != mnap_pkg::ChZ) begin
          err_upd   = 1'b1;
          phase_upd = mnap_pkg::PH_HALT;
        end else begin
          skip_upd  = '0;
          phase_upd = mnap_pkg::PH_NAME_LEN;
        end
      end
      mnap_pkg::PH_NAME_LEN, mnap_pkg::PH_P_LEN: begin
        if (is_digit) begin
          skip_upd = skip_acc;
        end else if (skip_count == '0) begin
          code_path = 1'b1;
        end else begin
          skip_upd  = skip_dec;
          phase_upd = (skip_dec == '0) ? mnap_pkg::PH_PARAMS : mnap_pkg::PH_SKIP;
        end
      end
      mnap_pkg::PH_SKIP: begin
        if (skip_count != '0) begin
          skip_upd = skip_dec;
        end
        if (skip_count == '0 || skip_dec == '0) begin
          phase_upd = mnap_pkg::PH_PARAMS;
        end
      end
      mnap_pkg::PH_PARAMS: begin
        code_path = 1'b1;
      end
      mnap_pkg::PH_AFTER_P: begin
        if (c == mnap_pkg::ChF || c == mnap_pkg::ChI) begin
          phase_upd = mnap_pkg::PH_PARAMS;
        end else if (is_digit) begin
          skip_upd  = SKIP_WIDTH'(digit);
          phase_upd = mnap_pkg::PH_P_LEN;
        end else begin
          err_upd   = 1'b1;
          phase_upd = mnap_pkg::PH_HALT;
        end
      end
      mnap_pkg::PH_S_SKIP: begin
        if (c == mnap_pkg::ChUnderscore) begin
          phase_upd = mnap_pkg::PH_PARAMS;
        end
      end
      mnap_pkg::PH_HALT: begin
        phase_upd = mnap_pkg::PH_HALT;
      end
      default: begin
        phase_upd = mnap_pkg::PH_HALT;
      end
    endcase

    if (code_path) begin
      phase_upd = mnap_pkg::PH_PARAMS;
      case (c) inside
        mnap_pkg::ChP, mnap_pkg::ChF, mnap_pkg::ChI, mnap_pkg::ChL, mnap_pkg::ChS: begin
          if (full) begin
            err_upd   = 1'b1;
            phase_upd = mnap_pkg::PH_HALT;
          end else begin
            a_valid  = 1'b1;
            a_handle = (c == mnap_pkg::ChP) || (c == mnap_pkg::ChS);
            cnt_upd  = param_count + 1'b1;
            if (c == mnap_pkg::ChP) begin
              if (last) begin
                err_upd   = 1'b1;
                phase_upd = mnap_pkg::PH_HALT;
              end else begin
                phase_upd = mnap_pkg::PH_AFTER_P;
              end
            end else if (c == mnap_pkg::ChS) begin
              phase_upd = mnap_pkg::PH_S_SKIP;
            end
          end
        end
        mnap_pkg::ChV: begin
          phase_upd = mnap_pkg::PH_HALT;
        end
        default: begin
          err_upd   = 1'b1;
          phase_upd = mnap_pkg::PH_HALT;
        end
      endcase
    end

    if (last) begin
      phase_next       = mnap_pkg::PH_PREFIX0;
      skip_next        = '0;
      param_count_next = '0;
      error_flag_next  = 1'b0;
    end else begin
      phase_next       = phase_upd;
      skip_next        = skip_upd;
      param_count_next = cnt_upd;
      error_flag_next  = err_upd;
    end
  end

  assign idx_ext = {7'd0, param_count};
  assign cnt_ext = {7'd0, cnt_upd};

  always_comb begin
    res_calc.arg_valid     = a_valid;
    res_calc.arg_is_handle = a_handle;
    res_calc.arg_index     = a_valid ? idx_ext[5:0] : 6'd0;
    res_calc.done_res      = last;
    res_calc.arg_count     = cnt_ext[6:0];
    res_calc.parse_error   = err_upd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= mnap_pkg::PH_PREFIX0;
      skip_count  <= '0;
      param_count <= '0;
      error_flag  <= 1'b0;
      res_valid   <= 1'b0;
    end else begin
      if (accept) begin
        phase       <= phase_next;
        skip_count  <= skip_next;
        param_count <= param_count_next;
        error_flag  <= error_flag_next;
        res_valid   <= 1'b1;
      end else if (!res_stall) begin
        res_valid   <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_word <= res_calc;
    end
  end

  a_last_restarts: assert property (@(posedge clk) disable iff (rst)
    accept && char_word.last_char |=>
      phase == mnap_pkg::PH_PREFIX0 && param_count == '0 && !error_flag)
    else $error("parser not back at start after final byte");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    param_count <= CW'(MAX_ARGS))
    else $error("parameter count above limit");

  a_error_halts: assert property (@(posedge clk) disable iff (rst)
    error_flag |-> phase == mnap_pkg::PH_HALT)
    else $error("error flag set outside halt phase");

  a_index_count: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_word.arg_valid |->
      res_word.arg_count[5:0] == res_word.arg_index + 6'd1)
    else $error("classified index does not match count");

  a_idle_fields: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_word.arg_valid |->
      !res_word.arg_is_handle && res_word.arg_index == 6'd0)
    else $error("parameter fields set without a classified parameter");

endmodule
